/* rtl/npt_pkg.sv */
// shared constants and types for the nearest point table
`default_nettype none

package npt_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int COORD_BITS  = 24;
    localparam int SLOT_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS    = $clog2(MAX_POINTS + 1);
    localparam int THR_BITS    = 24;
    localparam int RADIUS_BITS = 25;
    localparam int REQ_BITS    = 2;
    localparam int STATUS_BITS = 3;
    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = RADIUS_BITS;

    localparam int SQ_BITS   = 2 * COORD_BITS;
    localparam int RSQ_BITS  = 2 * RADIUS_BITS;
    localparam int DIST_BITS = (SQ_BITS + 1 > RSQ_BITS) ? SQ_BITS + 1 : RSQ_BITS;
    localparam int ENTRY_BITS = 2 * COORD_BITS;

    localparam int S_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int M_PAYLOAD_BITS = SLOT_BITS + 2 * COORD_BITS;
    localparam int M_DATA_BITS = ((M_PAYLOAD_BITS + 7) / 8) * 8;
    localparam int M_USER_BITS = STATUS_BITS;

    localparam logic [THR_BITS-1:0]    DUP_THRESHOLD_RESET = THR_BITS'(168);
    localparam logic [RADIUS_BITS-1:0] SEARCH_RADIUS_RESET = RADIUS_BITS'(18454938);

    localparam logic [CFG_ADDR_BITS-1:0] REG_DUP_THRESHOLD = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SEARCH_RADIUS = 1'b1;

    localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_QUERY  = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NONE      = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_CLEARED   = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_RESULT = 3'b100
    } state_t;

endpackage

`default_nettype wire

/* rtl/npt_ram.sv */
// generic simple dual port ram with registered read
`default_nettype none

module npt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/nearest_point_table.sv */
// nearest point table: point store with duplicate filtered insert and nearest query
//
// input stream s_*: one request word; s_tuser carries the request type (clear,
// insert, query) and s_tdata the x and y coordinates. every insert or query
// word yields exactly one result word on m_*; a request type of three is taken
// and dropped without a result.
// a clear returns its result without a scan. an insert or query reads every
// stored point from the point ram, one slot per cycle, through a three stage
// difference / square / compare pipeline, and its result is formed once the
// scan of count slots has drained from that pipeline, count being the number
// of stored points (at most 1024); on an empty table nothing is read. the
// single ram read port sets this scan rate.
// one request is worked on at a time; s_tready is high only between requests.
// a finished result waits in the output register while the receiver stalls,
// and the next request may be taken meanwhile; its result waits for the slot.
// the cfg port writes the duplicate threshold and the search radius and may
// be used only while the block is idle.
// after reset the table is empty, the registers hold their defaults and the
// ram contents are undefined; no clearing pass is needed.
`default_nettype none

module nearest_point_table
    import npt_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [S_DATA_BITS-1:0]   s_tdata,   // x_coord, y_coord
    input  wire logic [REQ_BITS-1:0]      s_tuser,   // req_type
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic      [M_DATA_BITS-1:0]   m_tdata,   // slot, near_x, near_y, zero pad
    output logic      [M_USER_BITS-1:0]   m_tuser,   // status
    input  wire logic                     cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    state_t state_reg, state_next;

    logic [REQ_BITS-1:0]    req_reg;
    logic [COORD_BITS-1:0]  qx_reg, qy_reg;
    logic [CNT_BITS-1:0]    n_reg, n_next;
    logic [CNT_BITS-1:0]    rd_idx_reg, rd_idx_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [THR_BITS-1:0]    dup_thr_reg;
    logic [RADIUS_BITS-1:0] radius_reg;

    logic                   p1_valid_reg;
    logic [SLOT_BITS-1:0]   p1_idx_reg;

    logic                   p2_valid_reg;
    logic [SLOT_BITS-1:0]   p2_idx_reg;
    logic [COORD_BITS-1:0]  p2_x_reg, p2_y_reg, p2_dx_reg, p2_dy_reg;
    logic                   p2_match_reg;

    logic                   p3_valid_reg;
    logic [SLOT_BITS-1:0]   p3_idx_reg;
    logic [COORD_BITS-1:0]  p3_x_reg, p3_y_reg;
    logic [SQ_BITS-1:0]     p3_sqx_reg, p3_sqy_reg;

    logic                   dup_found_reg;
    logic [SLOT_BITS-1:0]   dup_slot_reg;
    logic                   found_reg;
    logic [DIST_BITS-1:0]   best_reg;
    logic [SLOT_BITS-1:0]   best_slot_reg;
    logic [COORD_BITS-1:0]  best_x_reg, best_y_reg;

    logic                   m_valid_reg, m_valid_next;
    logic [STATUS_BITS-1:0] m_status_reg;
    logic [SLOT_BITS-1:0]   m_slot_reg;
    logic [COORD_BITS-1:0]  m_x_reg, m_y_reg;

    logic                   accept;
    logic                   issue;
    logic                   out_load;
    logic                   ram_we;
    logic [ENTRY_BITS-1:0]  ram_rdata;
    logic [COORD_BITS-1:0]  rd_x, rd_y, diff_x, diff_y;
    logic [COORD_BITS-1:0]  in_x, in_y;
    logic [DIST_BITS-1:0]   dist_sum;
    logic                   closer;
    logic [STATUS_BITS-1:0] res_status;
    logic [SLOT_BITS-1:0]   res_slot;
    logic [COORD_BITS-1:0]  res_x, res_y;

    assign in_x = s_tdata[COORD_BITS-1:0];
    assign in_y = s_tdata[2*COORD_BITS-1:COORD_BITS];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign issue    = (state_reg == S_SCAN) && (rd_idx_reg < n_reg);
    assign out_load = (state_reg == S_RESULT) && (!m_valid_reg || m_tready);
    assign ram_we   = out_load && (req_reg == REQ_INSERT) && !dup_found_reg
                      && (n_reg < CNT_BITS'(MAX_POINTS));

    npt_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (n_reg[SLOT_BITS-1:0]),
        .wdata ({qx_reg, qy_reg}),
        .re    (issue),
        .raddr (rd_idx_reg[SLOT_BITS-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_x   = ram_rdata[ENTRY_BITS-1:COORD_BITS];
    assign rd_y   = ram_rdata[COORD_BITS-1:0];
    assign diff_x = (qx_reg >= rd_x) ? qx_reg - rd_x : rd_x - qx_reg;
    assign diff_y = (qy_reg >= rd_y) ? qy_reg - rd_y : rd_y - qy_reg;

    assign dist_sum = DIST_BITS'(p3_sqx_reg) + DIST_BITS'(p3_sqy_reg);
    assign closer   = p3_valid_reg && (dist_sum < best_reg);

    // control path
    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        rd_idx_next  = rd_idx_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    n_next      = count_reg;
                    rd_idx_next = '0;
                    case (s_tuser)
                        REQ_CLEAR: begin
                            count_next = '0;
                            state_next = S_RESULT;
                        end
                        REQ_INSERT, REQ_QUERY: begin
                            state_next = S_SCAN;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (issue) begin
                    rd_idx_next = rd_idx_reg + CNT_BITS'(1);
                end else if (!p1_valid_reg && !p2_valid_reg && !p3_valid_reg) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    if (ram_we) begin
                        count_next = n_reg + CNT_BITS'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result word
    always_comb begin
        res_status = ST_NONE;
        res_slot   = '0;
        res_x      = '0;
        res_y      = '0;
        case (req_reg)
            REQ_CLEAR: begin
                res_status = ST_CLEARED;
            end
            REQ_INSERT: begin
                if (dup_found_reg) begin
                    res_status = ST_DUPLICATE;
                    res_slot   = dup_slot_reg;
                end else if (n_reg >= CNT_BITS'(MAX_POINTS)) begin
                    res_status = ST_FULL;
                end else begin
                    res_status = ST_INSERTED;
                    res_slot   = n_reg[SLOT_BITS-1:0];
                end
            end
            REQ_QUERY: begin
                if (found_reg) begin
                    res_status = ST_FOUND;
                    res_slot   = best_slot_reg;
                    res_x      = best_x_reg;
                    res_y      = best_y_reg;
                end
            end
            default: begin
                res_status = ST_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            n_reg        <= '0;
            rd_idx_reg   <= '0;
            m_valid_reg  <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            dup_thr_reg  <= DUP_THRESHOLD_RESET;
            radius_reg   <= SEARCH_RADIUS_RESET;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            n_reg        <= n_next;
            rd_idx_reg   <= rd_idx_next;
            m_valid_reg  <= m_valid_next;
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_DUP_THRESHOLD: dup_thr_reg <= cfg_wdata[THR_BITS-1:0];
                    REG_SEARCH_RADIUS: radius_reg  <= cfg_wdata[RADIUS_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg       <= s_tuser;
            qx_reg        <= in_x;
            qy_reg        <= in_y;
            dup_found_reg <= 1'b0;
            dup_slot_reg  <= '0;
            found_reg     <= 1'b0;
            best_reg      <= DIST_BITS'(RSQ_BITS'(radius_reg) * RSQ_BITS'(radius_reg));
            best_slot_reg <= '0;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
        end else begin
            // first matching slot wins the duplicate check
            if (p2_valid_reg && p2_match_reg && !dup_found_reg) begin
                dup_found_reg <= 1'b1;
                dup_slot_reg  <= p2_idx_reg;
            end
            // strict compare keeps the lowest slot on ties
            if (closer) begin
                found_reg     <= 1'b1;
                best_reg      <= dist_sum;
                best_slot_reg <= p3_idx_reg;
                best_x_reg    <= p3_x_reg;
                best_y_reg    <= p3_y_reg;
            end
        end

        p1_idx_reg <= rd_idx_reg[SLOT_BITS-1:0];

        p2_idx_reg   <= p1_idx_reg;
        p2_x_reg     <= rd_x;
        p2_y_reg     <= rd_y;
        p2_dx_reg    <= diff_x;
        p2_dy_reg    <= diff_y;
        p2_match_reg <= (diff_x <= dup_thr_reg) && (diff_y <= dup_thr_reg);

        p3_idx_reg <= p2_idx_reg;
        p3_x_reg   <= p2_x_reg;
        p3_y_reg   <= p2_y_reg;
        p3_sqx_reg <= SQ_BITS'(p2_dx_reg) * SQ_BITS'(p2_dx_reg);
        p3_sqy_reg <= SQ_BITS'(p2_dy_reg) * SQ_BITS'(p2_dy_reg);

        if (out_load) begin
            m_status_reg <= res_status;
            m_slot_reg   <= res_slot;
            m_x_reg      <= res_x;
            m_y_reg      <= res_y;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = M_DATA_BITS'({m_y_reg, m_x_reg, m_slot_reg});

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(MAX_POINTS))
        else $error("point count beyond table size");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            (count_reg == '0) || (count_reg == $past(count_reg) + CNT_BITS'(1)))
        else $error("point count moved by more than one");

    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(p1_valid_reg || p2_valid_reg || p3_valid_reg))
        else $error("request taken while scan pipeline busy");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// testbench for the nearest point table: directed and random request words checked against a table model
module tb_top
    import npt_pkg::*;
();

    localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = MAX_POINTS + 64;
    localparam int FILL_POINTS = 300;
    localparam logic [RADIUS_BITS-1:0] RADIUS_MAX = '1;
    localparam logic [THR_BITS-1:0] THR_MAX = '1;

    typedef struct packed {
        logic                  hold;
        logic [REQ_BITS-1:0]   req;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } point_req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [SLOT_BITS-1:0]   slot;
        logic [COORD_BITS-1:0]  near_x;
        logic [COORD_BITS-1:0]  near_y;
    } point_ans_t;

    logic                     aclk;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_DATA_BITS-1:0]   s_tdata = '0;
    logic [REQ_BITS-1:0]      s_tuser = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_DATA_BITS-1:0]   m_tdata;
    logic [M_USER_BITS-1:0]   m_tuser;
    logic                     cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    point_req_t request_q[$];
    point_ans_t answer_q[$];
    logic [2*COORD_BITS-1:0] recent_pts[$];

    // table model
    logic [COORD_BITS-1:0]  tab_x [MAX_POINTS];
    logic [COORD_BITS-1:0]  tab_y [MAX_POINTS];
    int unsigned            tab_count = 0;
    logic [THR_BITS-1:0]    thr_reg = DUP_THRESHOLD_RESET;
    logic [RADIUS_BITS-1:0] radius_reg = SEARCH_RADIUS_RESET;

    logic [THR_BITS-1:0] cur_thr = DUP_THRESHOLD_RESET;
    bit          steady = 1'b0;
    logic        word_taken = 1'b0;
    point_req_t  next_word;
    point_req_t  taken_word;
    point_ans_t  seen;
    point_ans_t  want;
    int unsigned err_count = 0;

    nearest_point_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic serve_request(input point_req_t r);
        point_ans_t a;
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic [DIST_BITS-1:0] sq_sum;
        logic [DIST_BITS-1:0] best;
        bit hit;
        a.status = ST_CLEARED;
        a.slot = '0;
        a.near_x = '0;
        a.near_y = '0;
        hit = 1'b0;
        case (r.req)
            REQ_CLEAR: begin
                tab_count = 0;
                answer_q = {answer_q, a};
            end
            REQ_INSERT: begin
                for (int i = 0; i < tab_count && !hit; i++) begin
                    dx = (r.x >= tab_x[i]) ? r.x - tab_x[i] : tab_x[i] - r.x;
                    dy = (r.y >= tab_y[i]) ? r.y - tab_y[i] : tab_y[i] - r.y;
                    if (dx <= thr_reg && dy <= thr_reg) begin
                        hit = 1'b1;
                        a.status = ST_DUPLICATE;
                        a.slot = SLOT_BITS'(i);
                    end
                end
                if (!hit) begin
                    if (tab_count >= MAX_POINTS) begin
                        a.status = ST_FULL;
                    end else begin
                        tab_x[tab_count] = r.x;
                        tab_y[tab_count] = r.y;
                        a.status = ST_INSERTED;
                        a.slot = SLOT_BITS'(tab_count);
                        tab_count++;
                    end
                end
                answer_q = {answer_q, a};
            end
            REQ_QUERY: begin
                best = DIST_BITS'(radius_reg) * DIST_BITS'(radius_reg);
                for (int i = 0; i < tab_count; i++) begin
                    dx = (r.x >= tab_x[i]) ? r.x - tab_x[i] : tab_x[i] - r.x;
                    dy = (r.y >= tab_y[i]) ? r.y - tab_y[i] : tab_y[i] - r.y;
                    sq_sum = DIST_BITS'(dx) * DIST_BITS'(dx) + DIST_BITS'(dy) * DIST_BITS'(dy);
                    if (sq_sum < best) begin
                        best = sq_sum;
                        a.slot = SLOT_BITS'(i);
                        hit = 1'b1;
                    end
                end
                if (hit) begin
                    a.status = ST_FOUND;
                    a.near_x = tab_x[a.slot];
                    a.near_y = tab_y[a.slot];
                end else begin
                    a.status = ST_NONE;
                end
                answer_q = {answer_q, a};
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [COORD_BITS-1:0] exp_v, got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
            err_count++;
        end
    endtask

    function automatic logic [COORD_BITS-1:0] rand_coord();
        return COORD_BITS'($urandom);
    endfunction

    // monitor and table update
    always @(posedge aclk) begin
        if (!aresetn) begin
            word_taken <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.status = m_tuser;
                seen.slot   = m_tdata[SLOT_BITS-1:0];
                seen.near_x = m_tdata[SLOT_BITS +: COORD_BITS];
                seen.near_y = m_tdata[SLOT_BITS+COORD_BITS +: COORD_BITS];
                if (answer_q.size() == 0) begin
                    $display("%0t: result word with nothing expected, status %0h slot %0h",
                             $time, seen.status, seen.slot);
                    err_count++;
                end else begin
                    want = answer_q.pop_front();
                    check_field("status", COORD_BITS'(want.status), COORD_BITS'(seen.status));
                    check_field("slot", COORD_BITS'(want.slot), COORD_BITS'(seen.slot));
                    check_field("near_x", want.near_x, seen.near_x);
                    check_field("near_y", want.near_y, seen.near_y);
                end
            end
            if (cfg_we) begin
                if (cfg_addr == REG_DUP_THRESHOLD)
                    thr_reg = cfg_wdata[THR_BITS-1:0];
                else if (cfg_addr == REG_SEARCH_RADIUS)
                    radius_reg = cfg_wdata;
            end
            word_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                taken_word.hold = 1'b0;
                taken_word.req  = s_tuser;
                taken_word.x    = s_tdata[COORD_BITS-1:0];
                taken_word.y    = s_tdata[COORD_BITS +: COORD_BITS];
                serve_request(taken_word);
            end
        end
    end

    // driver
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 23);
        if (aresetn && (word_taken || !s_tvalid)) begin
            if (request_q.size() != 0 && !(request_q[0].hold && answer_q.size() != 0)
                    && (steady || $urandom_range(99) >= 23)) begin
                next_word = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {next_word.y, next_word.x};
                s_tuser  <= next_word.req;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic queue_word(input logic [REQ_BITS-1:0] req,
                              input logic [COORD_BITS-1:0] x, y);
        point_req_t w;
        w.hold = ($urandom_range(99) < 2);
        w.req  = req;
        w.x    = x;
        w.y    = y;
        request_q = {request_q, w};
    endtask

    function automatic logic [COORD_BITS-1:0] jitter(input logic [COORD_BITS-1:0] base,
                                                     input logic [THR_BITS-1:0] thr);
        logic [COORD_BITS:0] d;
        case ($urandom_range(3))
            0: d = {1'b0, thr};
            1: d = {1'b0, thr} + (COORD_BITS+1)'(1);
            2: d = (COORD_BITS+1)'($urandom_range(thr));
            default: d = (COORD_BITS+1)'($urandom_range(255));
        endcase
        return $urandom_range(1) ? base + d[COORD_BITS-1:0] : base - d[COORD_BITS-1:0];
    endfunction

    task automatic wait_idle();
        while (request_q.size() != 0 || s_tvalid || answer_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [THR_BITS-1:0] thr,
                              input logic [RADIUS_BITS-1:0] rad);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_DUP_THRESHOLD;
        cfg_wdata <= CFG_DATA_BITS'(thr);
        @(negedge aclk);
        cfg_addr  <= REG_SEARCH_RADIUS;
        cfg_wdata <= rad;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cur_thr = thr;
    endtask

    // clear, fill 300 slots, then duplicates, inserts, an unused word, queries, a clear and a query
    task automatic fill_table();
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        queue_word(REQ_CLEAR, rand_coord(), rand_coord());
        for (int i = 0; i < FILL_POINTS; i++) begin
            x = COORD_BITS'((i << 14) | $urandom_range(16383));
            y = rand_coord();
            if (i == 0) begin
                x0 = x;
                y0 = y;
            end
            queue_word(REQ_INSERT, x, y);
        end
        queue_word(REQ_INSERT, x, y);
        queue_word(REQ_INSERT, x0, y0);
        repeat (3) queue_word(REQ_INSERT, rand_coord(), rand_coord());
        queue_word(REQ_UNUSED, rand_coord(), rand_coord());
        repeat (4) queue_word(REQ_QUERY, rand_coord(), rand_coord());
        queue_word(REQ_QUERY, '1, '0);
        queue_word(REQ_CLEAR, '0, '0);
        queue_word(REQ_QUERY, x0, y0);
    endtask

    task automatic run_phase(input int n_items);
        int done;
        int pick;
        logic [2*COORD_BITS-1:0] base;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        done = 0;
        recent_pts.delete();
        queue_word(REQ_CLEAR, rand_coord(), rand_coord());
        while (done < n_items) begin
            pick = $urandom_range(99);
            if (recent_pts.size() != 0)
                base = recent_pts[$urandom_range(recent_pts.size() - 1)];
            if (recent_pts.size() > 48 || (pick >= 87 && pick < 92)) begin
                queue_word(REQ_CLEAR, rand_coord(), rand_coord());
                recent_pts.delete();
                done++;
            end else if (pick < 35) begin
                x = rand_coord();
                y = rand_coord();
                queue_word(REQ_INSERT, x, y);
                recent_pts = {recent_pts, {y, x}};
                done++;
            end else if (pick < 52 && recent_pts.size() != 0) begin
                x = jitter(base[COORD_BITS-1:0], cur_thr);
                y = jitter(base[2*COORD_BITS-1:COORD_BITS], cur_thr);
                queue_word(REQ_INSERT, x, y);
                recent_pts = {recent_pts, {y, x}};
                done++;
            end else if (pick < 72) begin
                queue_word(REQ_QUERY, rand_coord(), rand_coord());
                done++;
            end else if (pick < 87 && recent_pts.size() != 0) begin
                queue_word(REQ_QUERY, jitter(base[COORD_BITS-1:0], cur_thr),
                           jitter(base[2*COORD_BITS-1:COORD_BITS], cur_thr));
                done++;
            end else if (pick < 97) begin
                queue_word(REQ_UNUSED, rand_coord(), rand_coord());
            end else begin
                x = $urandom_range(1) ? '1 : '0;
                y = $urandom_range(1) ? '1 : '0;
                queue_word($urandom_range(1) ? REQ_INSERT : REQ_QUERY, x, y);
                done++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty table, duplicate edges, ties, ignored word, clear keeps nothing
        queue_word(REQ_QUERY, 24'h123456, 24'h654321);
        queue_word(REQ_CLEAR, '1, '1);
        queue_word(REQ_INSERT, '0, '0);
        queue_word(REQ_INSERT, '1, '1);
        queue_word(REQ_INSERT, 24'd168, 24'd0);
        queue_word(REQ_INSERT, 24'd169, 24'd5);
        queue_word(REQ_INSERT, 24'hFFFFFF - 24'd168, 24'hFFFFFF);
        queue_word(REQ_INSERT, 24'h100000, 24'h300000);
        queue_word(REQ_INSERT, 24'h300000, 24'h100000);
        queue_word(REQ_QUERY, '0, '0);
        queue_word(REQ_QUERY, 24'h200000, 24'h200000);
        queue_word(REQ_QUERY, '1, '0);
        queue_word(REQ_QUERY, '0, '1);
        queue_word(REQ_UNUSED, 24'hA5A5A5, 24'h5A5A5A);
        queue_word(REQ_QUERY, 24'h7FFFFF, 24'h800000);
        queue_word(REQ_CLEAR, '0, '0);
        queue_word(REQ_QUERY, '0, '0);
        queue_word(REQ_INSERT, 24'h000001, 24'hFFFFFE);
        queue_word(REQ_QUERY, 24'h000001, 24'hFFFFFE);
        wait_idle();

        set_config('0, RADIUS_MAX);
        fill_table();
        wait_idle();

        set_config(DUP_THRESHOLD_RESET, SEARCH_RADIUS_RESET);
        steady = 1'b1;
        run_phase(50);
        wait_idle();
        steady = 1'b0;

        set_config('0, '0);
        run_phase(40);
        wait_idle();

        set_config(THR_MAX, RADIUS_MAX);
        run_phase(40);
        wait_idle();

        set_config(THR_BITS'($urandom_range(1 << 16)),
                   RADIUS_BITS'($urandom_range(1 << 24, 1 << 20)));
        run_phase(40);
        wait_idle();

        set_config(THR_BITS'($urandom_range(1 << 22, 1 << 16)),
                   RADIUS_BITS'($urandom_range(1 << 20, 1 << 12)));
        run_phase(40);
        wait_idle();

        set_config(THR_BITS'(1), RADIUS_BITS'(1));
        run_phase(30);
        wait_idle();

        if (err_count == 0 && answer_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            if (answer_q.size() != 0)
                $display("%0t: %0d expected results never arrived", $time, answer_q.size());
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(64'd80_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
rtl/npt_pkg.sv
rtl/npt_ram.sv
rtl/nearest_point_table.sv
verif/tb_top.sv
